/* sv/pbs_pkg.sv */
`timescale 1ns / 1ps

package pbs_pkg;

  // Field and register widths
  localparam int unsigned PIX_W  = 16;
  localparam int unsigned SUM_W  = 26;
  localparam int unsigned BF_W   = 6;
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned CFG_W  = 13;
  localparam int unsigned IDX_W  = 2;

  // Largest image height and width
  localparam int unsigned MAX_ROWS    = 4096;
  localparam int unsigned MAX_COLUMNS = 4096;

  // Saturation limit of a bin sum and largest bin edge
  localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(65535);
  localparam logic [BF_W-1:0]  MAX_BIN   = BF_W'(32);

  // Register indexes
  typedef enum logic [IDX_W-1:0] {
    CFG_BIN_FACTOR   = 2'd0,
    CFG_ROW_COUNT    = 2'd1,
    CFG_COLUMN_COUNT = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_e;

  // Pending memory operation of one pixel that closes a bin column segment
  typedef struct packed {
    logic             emit;
    logic             use_mem;
    logic             last;
    logic [SUM_W-1:0] sum;
  } seg_op_t;

endpackage

/* sv/pbs_ram.sv */
`timescale 1ns / 1ps

module pbs_ram #(
  parameter int unsigned WIDTH = 26,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held while not enabled
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/pixel_binning_saturating.sv */
`timescale 1ns / 1ps

// Square pixel binning with saturation.
// Pixels enter on the s_axis channel in memory order: row index fastest,
// columns outermost. Each bin of bin_factor by bin_factor pixels is summed
// and its sum, saturated at 65535, leaves on the m_axis channel when the
// last pixel of the bin arrives; tlast marks the final bin of an image.
// Leftover rows and columns are consumed and dropped.
// Throughput: one pixel per cycle unless the output stalls. The block keeps
// one partial column sum per output row in a single RAM with one write and
// one registered read port. A pixel that closes a bin column segment reads
// its entry at acceptance unless its column is the first of its bin; the
// segment stage then writes the sum back, or emits it into the output
// register, from which it leaves on the m_axis channel when it is taken.
// When the receiver stalls, the output register holds its transaction and
// one more segment operation may wait behind it; then s_axis_tready drops.
// Reset (rst_ni low, asynchronous) sets bin_factor 1 and both counts 4096
// and starts a new image. Each write to a used register restarts the image;
// write configuration only while the block is idle. No clearing pass runs.
module pixel_binning_saturating
  import pbs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // Configuration
  input  logic             cfg_we_i,
  input  logic [IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  // Pixel stream in
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [PIX_W-1:0] s_axis_tdata,   // [15:0] pixel
  // Bin stream out
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [PIX_W-1:0] m_axis_tdata,   // [15:0] binned_value
  output logic             m_axis_tlast    // last_of_image
);

  localparam int unsigned AW = $clog2(MAX_ROWS);

  // Clamped configuration
  logic [BF_W-1:0]  bf_q;
  logic [CNT_W-1:0] rows_q, cols_q;

  // Image position
  logic [CNT_W-1:0] rp_q, rp_d, cp_q, cp_d;
  logic [BF_W-2:0]  rib_q, rib_d, cib_q, cib_d;
  logic [AW-1:0]    orow_q, orow_d;
  logic [SUM_W-1:0] run_q, run_d;

  // Segment stage
  logic             s1_valid_q;
  seg_op_t          s1_q, s1_d;
  logic [AW-1:0]    s1_addr_q;
  logic             s1_fire;
  logic [SUM_W-1:0] total;

  // Output register
  logic             out_valid_q;
  logic [PIX_W-1:0] out_data_q;
  logic             out_last_q;

  logic             accept;
  logic             seg_end;
  logic [SUM_W-1:0] ram_rdata;
  logic             ram_we, ram_re;
  logic [CNT_W:0]   row_reach, col_reach;

  function automatic logic [CNT_W-1:0] clamp_count(logic [CFG_W-1:0] v, int unsigned hi);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (32'(v) > hi) begin
      r = CNT_W'(hi);
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign seg_end = (BF_W'(rib_q) == bf_q - BF_W'(1));

  // Stage advances unless it must emit into an occupied output register that the receiver stalls
  assign s1_fire       = s1_valid_q && (!s1_q.emit || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_fire;

  // Accumulate the current column segment
  assign run_d = (rib_q == '0) ? SUM_W'(s_axis_tdata) : run_q + SUM_W'(s_axis_tdata);

  // Last bin when no further whole bin fits in either direction
  assign row_reach = {1'b0, rp_q} + (CNT_W+1)'(bf_q);
  assign col_reach = {1'b0, cp_q} + (CNT_W+1)'(bf_q);

  always_comb begin
    s1_d.emit    = (BF_W'(cib_q) == bf_q - BF_W'(1));
    s1_d.use_mem = (cib_q != '0);
    s1_d.last    = (row_reach >= {1'b0, rows_q}) && (col_reach >= {1'b0, cols_q});
    s1_d.sum     = run_d;
  end

  // Advance the position counters
  always_comb begin
    rp_d   = rp_q + CNT_W'(1);
    cp_d   = cp_q;
    cib_d  = cib_q;
    rib_d  = seg_end ? '0 : rib_q + 1'b1;
    orow_d = seg_end ? orow_q + AW'(1) : orow_q;
    if (rp_d == rows_q) begin
      rp_d   = '0;
      rib_d  = '0;
      orow_d = '0;
      cp_d   = cp_q + CNT_W'(1);
      cib_d  = (BF_W'(cib_q) == bf_q - BF_W'(1)) ? '0 : cib_q + 1'b1;
      if (cp_d == cols_q) begin
        cp_d  = '0;
        cib_d = '0;
      end
    end
  end

  // Hold configuration and position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bf_q   <= BF_W'(1);
      rows_q <= CNT_W'(4096);
      cols_q <= CNT_W'(4096);
      rp_q   <= '0;
      cp_q   <= '0;
      rib_q  <= '0;
      cib_q  <= '0;
      orow_q <= '0;
      run_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_BIN_FACTOR: begin
          if (cfg_data_i[BF_W-1:0] == '0) begin
            bf_q <= BF_W'(1);
          end else if (cfg_data_i[BF_W-1:0] > MAX_BIN) begin
            bf_q <= MAX_BIN;
          end else begin
            bf_q <= cfg_data_i[BF_W-1:0];
          end
        end
        CFG_ROW_COUNT:    rows_q <= clamp_count(cfg_data_i, MAX_ROWS);
        CFG_COLUMN_COUNT: cols_q <= clamp_count(cfg_data_i, MAX_COLUMNS);
        default: ;
      endcase
      if (cfg_idx_e'(cfg_idx_i) != CFG_UNUSED) begin
        rp_q   <= '0;
        cp_q   <= '0;
        rib_q  <= '0;
        cib_q  <= '0;
        orow_q <= '0;
        run_q  <= '0;
      end
    end else if (accept) begin
      rp_q   <= rp_d;
      cp_q   <= cp_d;
      rib_q  <= rib_d;
      cib_q  <= cib_d;
      orow_q <= orow_d;
      run_q  <= run_d;
    end
  end

  // Load the segment stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid_q <= accept && seg_end;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && seg_end) begin
      s1_q      <= s1_d;
      s1_addr_q <= orow_q;
    end
  end

  // Partial column sums, one per output row
  assign ram_re = accept && seg_end && s1_d.use_mem;
  assign ram_we = s1_fire && !s1_q.emit;
  assign total  = s1_q.use_mem ? ram_rdata + s1_q.sum : s1_q.sum;

  pbs_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_ROWS)
  ) u_partial (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_addr_q),
    .wdata_i (total),
    .re_i    (ram_re),
    .raddr_i (orow_q),
    .rdata_o (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_fire && s1_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_fire && s1_q.emit) begin
      out_data_q <= (total > SAT_LIMIT) ? PIX_W'(SAT_LIMIT) : total[PIX_W-1:0];
      out_last_q <= s1_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  // Checks
  a_ready_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && ram_re) |-> (s1_addr_q != orow_q))
    else $error("read and write of the same partial sum in one cycle");

  a_bin_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (BF_W'(rib_q) < bf_q) && (BF_W'(cib_q) < bf_q))
    else $error("position inside bin beyond bin factor");

endmodule
